// ----- hw/rtl/pdc_pkg.sv -----
// shared types, default settings and coding constants for the pwm period and dead-time calculator
package pdc_pkg;

    localparam longint unsigned CLOCK_HZ_DEF = 64'd180000000;
    localparam longint unsigned FREQ_MIN_DEF = 64'd20000;
    localparam longint unsigned FREQ_MAX_DEF = 64'd200000;
    localparam longint unsigned DEAD_MIN_DEF = 64'd100;
    localparam longint unsigned DEAD_MAX_DEF = 64'd1000;

    localparam longint unsigned NS_PER_S = 64'd1000000000;
    localparam longint unsigned NS_HALF  = 64'd500000000;
    localparam int unsigned     NS_DIV_W = 30;

    localparam logic [7:0]  CODE_EXT   = 8'h80;
    localparam logic [31:0] STEP_MAX   = 32'd127;
    localparam logic [31:0] EXT_BIAS   = 32'd64;
    localparam logic [31:0] EXT_MAX    = 32'd63;
    localparam logic [31:0] RELOAD_CAP = 32'd65536;
    localparam logic [15:0] RELOAD_MAX = 16'hffff;

    typedef struct packed {
        logic [31:0] freq_hz;
        logic [15:0] deadtime_ns;
    } req_word_t;

    typedef struct packed {
        logic [15:0] period_reload;
        logic [15:0] compare_half;
        logic [7:0]  deadtime_code;
    } res_word_t;

endpackage

// ----- hw/rtl/pdc_cell.sv -----
// one restoring division step: takes a dividend bit, yields a quotient bit
module pdc_cell #(
    parameter int unsigned DW = 8,
    parameter int unsigned NB = 8
) (
    input  logic          clk,
    input  logic          en,
    input  logic [DW-1:0] rem_in,
    input  logic [NB-1:0] bits_in,
    input  logic [NB-1:0] quot_in,
    input  logic [DW-1:0] div_in,
    output logic [DW-1:0] rem,
    output logic [NB-1:0] bits,
    output logic [NB-1:0] quot,
    output logic [DW-1:0] div
);

    logic [DW-1:0] rem_reg,  rem_next;
    logic [NB-1:0] bits_reg, bits_next;
    logic [NB-1:0] quot_reg, quot_next;
    logic [DW-1:0] div_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    assign trial = {rem_in, bits_in[NB-1]};
    assign diff  = trial - {1'b0, div_in};
    assign ge    = (trial >= {1'b0, div_in});

    // partial remainder stays below the divisor, so it fits DW bits
    assign rem_next  = ge ? diff[DW-1:0] : trial[DW-1:0];
    assign bits_next = bits_in << 1;
    assign quot_next = (quot_in << 1) | NB'(ge);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            bits_reg <= bits_next;
            quot_reg <= quot_next;
            div_reg  <= div_in;
        end
    end

    assign rem  = rem_reg;
    assign bits = bits_reg;
    assign quot = quot_reg;
    assign div  = div_reg;

endmodule

// ----- hw/rtl/pdc_out.sv -----
// saturation and dead-time encoding, output register and skid word
module pdc_out #(
    parameter int unsigned NB = 8,
    parameter int unsigned DW = 30
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid,
    input  logic [NB-1:0]      period_quot,
    input  logic [NB-1:0]      dead_quot,
    input  logic [DW-1:0]      dead_rem,
    input  logic               stall,
    output logic               res_valid,
    output pdc_pkg::res_word_t res_word,
    output logic               hold
);

    logic [31:0]        pq;
    logic [15:0]        reload;
    logic [16:0]        reload_inc;
    logic               round_up;
    logic [NB:0]        steps;
    logic [NB-1:0]      half;
    logic [31:0]        half_w;
    logic [31:0]        ext;
    logic [7:0]         code;
    pdc_pkg::res_word_t enc;

    logic               l_valid_reg;
    pdc_pkg::res_word_t l_word_reg;
    logic               skid_valid_reg;
    pdc_pkg::res_word_t skid_word_reg;

    always_comb
    begin
        pq = 32'(period_quot);
        priority if (pq == 32'd0)
            reload = 16'd0;
        else if (pq > pdc_pkg::RELOAD_CAP)
            reload = pdc_pkg::RELOAD_MAX;
        else
            reload = 16'(pq - 32'd1);
        reload_inc = {1'b0, reload} + 17'd1;

        // round to nearest, ties up, from floor quotient and remainder
        round_up = (dead_rem >= DW'(pdc_pkg::NS_HALF));
        steps    = {1'b0, dead_quot} + (NB+1)'(round_up);
        half     = dead_quot >> 1;
        half_w   = 32'(half);
        priority if (half_w < pdc_pkg::EXT_BIAS)
            ext = 32'd0;
        else if (half_w - pdc_pkg::EXT_BIAS > pdc_pkg::EXT_MAX)
            ext = pdc_pkg::EXT_MAX;
        else
            ext = half_w - pdc_pkg::EXT_BIAS;
        if (32'(steps) <= pdc_pkg::STEP_MAX)
            code = 8'(steps);
        else
            code = pdc_pkg::CODE_EXT | 8'(ext);

        enc.period_reload = reload;
        enc.compare_half  = reload_inc[16:1];
        enc.deadtime_code = code;
    end

    // the row only moves while the skid word is free
    assign hold = skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!skid_valid_reg)
        begin
            l_valid_reg <= valid;
            if (l_valid_reg && stall)
                skid_valid_reg <= 1'b1;
        end
        else if (!stall)
        begin
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg)
        begin
            l_word_reg    <= enc;
            skid_word_reg <= l_word_reg;
        end
    end

    assign res_valid = skid_valid_reg | l_valid_reg;
    assign res_word  = skid_valid_reg ? skid_word_reg : l_word_reg;

    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && stall |=> skid_valid_reg && $stable(skid_word_reg))
        else $error("skid word changed while stalled");

    a_code_form: assert property (@(posedge clk) disable iff (!rst_n)
        l_valid_reg |-> l_word_reg.deadtime_code[7:6] != 2'b11)
        else $error("dead-time code outside both forms");

    a_half_sat: assert property (@(posedge clk) disable iff (!rst_n)
        l_valid_reg && l_word_reg.period_reload == pdc_pkg::RELOAD_MAX
            |-> l_word_reg.compare_half == 16'h8000)
        else $error("compare value wrong at saturated reload");

endmodule

// ----- hw/rtl/pwm_period_and_deadtime_calc.sv -----
// pwm period and dead-time calculator: clamp and multiply, a row of divider cells, encoder
// a front register, the row of divider cells and the output register lie between an accepted
// request and its result word; N = quotient width of the wider of the two divisions (N = 14 by default)
// throughput: one word per cycle while the skid word is free; each cell of the row resolves one
// quotient bit of the period division and of the dead-time division side by side
// reset: clears the valid flags of the row, the output word and the skid word
module pwm_period_and_deadtime_calc #(
    parameter longint unsigned CLOCK_HZ = pdc_pkg::CLOCK_HZ_DEF,
    parameter longint unsigned FREQ_MIN = pdc_pkg::FREQ_MIN_DEF,
    parameter longint unsigned FREQ_MAX = pdc_pkg::FREQ_MAX_DEF,
    parameter longint unsigned DEAD_MIN = pdc_pkg::DEAD_MIN_DEF,
    parameter longint unsigned DEAD_MAX = pdc_pkg::DEAD_MAX_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  pdc_pkg::req_word_t req_word,
    output logic               res_valid,
    input  logic               res_stall,
    output pdc_pkg::res_word_t res_word
);

    // the upper limit wins when the limits cross
    localparam longint unsigned F_LO  = (FREQ_MAX < FREQ_MIN) ? FREQ_MAX : FREQ_MIN;
    localparam longint unsigned F_LO1 = (F_LO == 0) ? 64'd1 : F_LO;
    localparam int unsigned FW_R  = $clog2(FREQ_MAX + 1);
    localparam int unsigned FW    = (FW_R < 1) ? 1 : FW_R;
    localparam int unsigned QP_R  = $clog2(CLOCK_HZ / F_LO1 + 1);
    localparam int unsigned QP    = (QP_R < 1) ? 1 : QP_R;
    localparam int unsigned NSW_R = $clog2(DEAD_MAX + 1);
    localparam int unsigned NSW   = (NSW_R < 1) ? 1 : NSW_R;
    localparam int unsigned CW    = $clog2(CLOCK_HZ + 1);
    localparam int unsigned PW    = NSW + CW;
    localparam int unsigned QD_R  = $clog2(DEAD_MAX * CLOCK_HZ / pdc_pkg::NS_PER_S + 1);
    localparam int unsigned QD    = (QD_R < 1) ? 1 : QD_R;
    localparam int unsigned N     = (QP > QD) ? QP : QD;
    localparam int unsigned DW    = pdc_pkg::NS_DIV_W;

    logic            en;
    logic            hold;
    logic [31:0]     f_lo_cl;
    logic [31:0]     f_cl;
    logic [FW-1:0]   f_eff;
    logic [15:0]     d_lo_cl;
    logic [15:0]     d_cl;
    logic [NSW-1:0]  nsc;
    logic [CW-1:0]   clk_const;
    logic [PW-1:0]   prod;

    logic            front_valid_reg;
    logic [FW-1:0]   f_reg;
    logic [PW-1:0]   prod_reg;
    logic [N-1:0]    cell_valid_reg;

    logic [FW-1:0]   p_rem  [N+1];
    logic [N-1:0]    p_bits [N+1];
    logic [N-1:0]    p_quot [N+1];
    logic [FW-1:0]   p_div  [N+1];
    logic [DW-1:0]   d_rem  [N+1];
    logic [N-1:0]    d_bits [N+1];
    logic [N-1:0]    d_quot [N+1];
    logic [DW-1:0]   d_div  [N+1];

    assign en        = !hold;
    assign req_stall = hold;

    always_comb
    begin
        f_lo_cl = (req_word.freq_hz < 32'(FREQ_MIN)) ? 32'(FREQ_MIN) : req_word.freq_hz;
        f_cl    = (f_lo_cl > 32'(FREQ_MAX)) ? 32'(FREQ_MAX) : f_lo_cl;
        f_eff   = (f_cl == 32'd0) ? FW'(1) : FW'(f_cl);
        d_lo_cl = (req_word.deadtime_ns < 16'(DEAD_MIN)) ? 16'(DEAD_MIN) : req_word.deadtime_ns;
        d_cl    = (d_lo_cl > 16'(DEAD_MAX)) ? 16'(DEAD_MAX) : d_lo_cl;
        nsc     = NSW'(d_cl);
    end

    assign clk_const = CW'(CLOCK_HZ);
    assign prod      = nsc * clk_const;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
            cell_valid_reg  <= '0;
        end
        else if (en)
        begin
            front_valid_reg <= req_valid;
            cell_valid_reg  <= (cell_valid_reg << 1) | N'(front_valid_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_reg    <= f_eff;
            prod_reg <= prod;
        end
    end

    // quotients fit N bits, so the dividend from bit N up starts as the remainder
    assign p_rem[0]  = FW'(CLOCK_HZ >> N);
    assign p_bits[0] = N'(CLOCK_HZ);
    assign p_quot[0] = '0;
    assign p_div[0]  = f_reg;
    assign d_rem[0]  = DW'(prod_reg >> N);
    assign d_bits[0] = N'(prod_reg);
    assign d_quot[0] = '0;
    assign d_div[0]  = DW'(pdc_pkg::NS_PER_S);

    for (genvar k = 0; k < N; k++)
    begin : g_row
        pdc_cell #(
            .DW (FW),
            .NB (N)
        ) u_period (
            .clk     (clk),
            .en      (en),
            .rem_in  (p_rem[k]),
            .bits_in (p_bits[k]),
            .quot_in (p_quot[k]),
            .div_in  (p_div[k]),
            .rem     (p_rem[k+1]),
            .bits    (p_bits[k+1]),
            .quot    (p_quot[k+1]),
            .div     (p_div[k+1])
        );

        pdc_cell #(
            .DW (DW),
            .NB (N)
        ) u_dead (
            .clk     (clk),
            .en      (en),
            .rem_in  (d_rem[k]),
            .bits_in (d_bits[k]),
            .quot_in (d_quot[k]),
            .div_in  (d_div[k]),
            .rem     (d_rem[k+1]),
            .bits    (d_bits[k+1]),
            .quot    (d_quot[k+1]),
            .div     (d_div[k+1])
        );
    end

    pdc_out #(
        .NB (N),
        .DW (DW)
    ) u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .valid       (cell_valid_reg[N-1]),
        .period_quot (p_quot[N]),
        .dead_quot   (d_quot[N]),
        .dead_rem    (d_rem[N]),
        .stall       (res_stall),
        .res_valid   (res_valid),
        .res_word    (res_word),
        .hold        (hold)
    );

    a_row_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        hold |=> $stable(cell_valid_reg) && $stable(front_valid_reg))
        else $error("divider row moved while the skid word was full");

endmodule

// ----- verif/pwm_period_and_deadtime_calc_tb.sv -----
// testbench for the pwm period and dead-time calculator: directed and random words, scoreboard
`timescale 1ns / 100ps

module pwm_period_and_deadtime_calc_tb;

    localparam longint unsigned CLK_HZ   = pdc_pkg::CLOCK_HZ_DEF;
    localparam longint unsigned F_MIN    = pdc_pkg::FREQ_MIN_DEF;
    localparam longint unsigned F_MAX    = pdc_pkg::FREQ_MAX_DEF;
    localparam longint unsigned D_MIN    = pdc_pkg::DEAD_MIN_DEF;
    localparam longint unsigned D_MAX    = pdc_pkg::DEAD_MAX_DEF;
    localparam int unsigned RANDOM_WORDS = 480;
    localparam int unsigned QUIET_TAIL   = 60;
    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    class pwm_setting_board;
        pdc_pkg::res_word_t pending_settings[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        // clamp, divide and encode, all in 64-bit integers
        function pdc_pkg::res_word_t settings_for(pdc_pkg::req_word_t w);
            longint unsigned f, q, reload, ns, prod, steps, half, ext;
            pdc_pkg::res_word_t r;
            f = w.freq_hz;
            if (f < F_MIN) f = F_MIN;
            if (f > F_MAX) f = F_MAX;
            if (f == 0) f = 1;
            q = CLK_HZ / f;
            if (q == 0) reload = 0;
            else if (q - 1 > pdc_pkg::RELOAD_MAX) reload = pdc_pkg::RELOAD_MAX;
            else reload = q - 1;
            r.period_reload = reload[15:0];
            r.compare_half  = 16'((reload + 1) / 2);
            ns = w.deadtime_ns;
            if (ns < D_MIN) ns = D_MIN;
            if (ns > D_MAX) ns = D_MAX;
            prod  = ns * CLK_HZ;
            steps = (prod + pdc_pkg::NS_HALF) / pdc_pkg::NS_PER_S;
            if (steps <= pdc_pkg::STEP_MAX)
            begin
                r.deadtime_code = steps[7:0];
            end
            else
            begin
                half = prod / (2 * pdc_pkg::NS_PER_S);
                ext  = (half < pdc_pkg::EXT_BIAS) ? 0 : half - pdc_pkg::EXT_BIAS;
                if (ext > pdc_pkg::EXT_MAX) ext = pdc_pkg::EXT_MAX;
                r.deadtime_code = pdc_pkg::CODE_EXT | ext[7:0];
            end
            return r;
        endfunction

        function void note_request(pdc_pkg::req_word_t w);
            pending_settings.push_back(settings_for(w));
        endfunction

        function void check_result(pdc_pkg::res_word_t got);
            pdc_pkg::res_word_t want;
            if (pending_settings.size() == 0)
            begin
                errors++;
                $display("%0t: result word %h with nothing expected", $time, got);
                return;
            end
            want = pending_settings.pop_front();
            if (got.period_reload !== want.period_reload)
            begin
                errors++;
                $display("%0t: period_reload expected %0d got %0d", $time,
                         want.period_reload, got.period_reload);
            end
            if (got.compare_half !== want.compare_half)
            begin
                errors++;
                $display("%0t: compare_half expected %0d got %0d", $time,
                         want.compare_half, got.compare_half);
            end
            if (got.deadtime_code !== want.deadtime_code)
            begin
                errors++;
                $display("%0t: deadtime_code expected %h got %h", $time,
                         want.deadtime_code, got.deadtime_code);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    pdc_pkg::req_word_t req_word = '0;
    logic               res_valid;
    logic               res_stall = 1'b0;
    pdc_pkg::res_word_t res_word;

    pwm_setting_board board;
    bit          idling_on = 1'b1;
    bit          long_hold_pending = 1'b0;
    int unsigned hold_left = 0;
    int unsigned cycle_count = 0;

    pwm_period_and_deadtime_calc #(
        .CLOCK_HZ(CLK_HZ),
        .FREQ_MIN(F_MIN),
        .FREQ_MAX(F_MAX),
        .DEAD_MIN(D_MIN),
        .DEAD_MAX(D_MAX)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_word(req_word),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res_word(res_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("pwm_period_and_deadtime_calc: mismatch");
            $finish;
        end
    end

    // result side: check accepted words, then choose next cycle's stall
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            board.check_result(res_word);
        if (long_hold_pending)
        begin
            long_hold_pending = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            res_stall <= 1'b1;
            hold_left--;
        end
        else if (idling_on && $urandom_range(0, 4) == 0)
        begin
            res_stall <= 1'b1;
            hold_left = $urandom_range(0, 4);
        end
        else
        begin
            res_stall <= 1'b0;
        end
    end

    task automatic send_request(input pdc_pkg::req_word_t w);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_word  <= w;
        do @(posedge clk); while (req_stall);
        board.note_request(w);
    endtask

    function automatic pdc_pkg::req_word_t random_request();
        pdc_pkg::req_word_t w;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: w.freq_hz = $urandom_range(int'(F_MIN), int'(F_MAX));
            6, 7:             w.freq_hz = $urandom();
            8:                w.freq_hz = $urandom_range(0, int'(2 * F_MAX));
            default:          w.freq_hz = $urandom_range(0, 1) ?
                                  $urandom_range(int'(F_MIN) - 2, int'(F_MIN) + 2) :
                                  $urandom_range(int'(F_MAX) - 2, int'(F_MAX) + 2);
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: w.deadtime_ns = $urandom_range(int'(D_MIN), int'(D_MAX));
            6, 7:             w.deadtime_ns = $urandom_range(0, 16'hffff);
            // around the change from step form to extended form
            8:                w.deadtime_ns = $urandom_range(700, 730);
            default:          w.deadtime_ns = $urandom_range(0, 1) ?
                                  $urandom_range(0, int'(D_MIN) + 2) :
                                  $urandom_range(int'(D_MAX) - 2, int'(D_MAX) + 2);
        endcase
        return w;
    endfunction

    initial
    begin
        logic [31:0] freq_set[14];
        logic [15:0] dead_set[17];
        pdc_pkg::req_word_t w;
        board = new();
        // below and above both limits, above the clock, and low enough to saturate if unclamped
        freq_set = '{32'd0, 32'd1, 32'd19999, 32'd20000, 32'd20001, 32'd100000,
                     32'd199999, 32'd200000, 32'd200001, 32'd180000000, 32'd180000001,
                     32'hffffffff, 32'd2746, 32'h80000000};
        // limits, rounding edges of the step form and the start of the extended form
        dead_set = '{16'd0, 16'd99, 16'd100, 16'd101, 16'd555, 16'd705, 16'd706, 16'd708,
                     16'd709, 16'd711, 16'd712, 16'd718, 16'd723, 16'd999, 16'd1000,
                     16'd1001, 16'hffff};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < 17; i++)
        begin
            w.freq_hz     = freq_set[i % 14];
            w.deadtime_ns = dead_set[i];
            send_request(w);
        end
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            idling_on = (i < RANDOM_WORDS - QUIET_TAIL) && ((i / 120) % 2 == 0);
            if (i == 40)
                long_hold_pending = 1'b1;
            send_request(random_request());
        end
        req_valid <= 1'b0;
        while (board.pending_settings.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("pwm_period_and_deadtime_calc: match");
        else
            $display("pwm_period_and_deadtime_calc: mismatch");
        $finish;
    end

endmodule
